### rtl/gcem_pkg.sv
// Types and constants shared by the grammar codon expression mapper.
// Holds the request and response beat formats, symbol, token and status codes.
// No dependencies.
`timescale 1ns / 1ps

package gcem_pkg;

   // Request beat: op selects start or apply codon
   typedef struct packed {
      logic       op;
      logic [7:0] codon;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [3:0] token;
      logic [1:0] status;
      logic [7:0] string_length;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      SYM_E     = 2'd0,
      SYM_O     = 2'd1,
      SYM_V     = 2'd2,
      SYM_CLOSE = 2'd3
   } sym_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_CHECK,
      ST_PUSH,
      ST_FINISH,
      ST_EMIT
   } map_state_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_CODON = 1'b1;

   localparam logic [3:0] TOK_NONE  = 4'd0;
   localparam logic [3:0] TOK_VAR   = 4'd1;  // x, y, one follow
   localparam logic [3:0] TOK_ARITH = 4'd4;  // plus, minus, times follow
   localparam logic [3:0] TOK_OPEN  = 4'd7;
   localparam logic [3:0] TOK_CLOSE = 4'd8;

   localparam logic [1:0] STAT_RUN  = 2'd0;
   localparam logic [1:0] STAT_DONE = 2'd1;
   localparam logic [1:0] STAT_LONG = 2'd2;
   localparam logic [1:0] STAT_IDLE = 2'd3;

   localparam logic [7:0] LEN_START   = 8'd9;
   localparam logic [7:0] MAX_LEN_RST = 8'd200;
   localparam logic [5:0] PRE_MAX     = 6'd31;
   localparam logic [6:0] MAX_BEATS   = 7'd32;

   // Residue mod 3 of a byte: 4 = 1 (mod 3), so base-4 digits may be summed
   function automatic logic [1:0] mod3_u8(input logic [7:0] v);
      logic [3:0] s;
      logic [2:0] t;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
      t = 3'(s[3:2]) + 3'(s[1:0]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

endpackage

### rtl/grammar_codon_expression_mapper_core.sv
// Grammar codon expression mapper, top level.
// Depends on gcem_pkg for beat formats, codes and the mod 3 helper.
`timescale 1ns / 1ps

// Usage
//  req channel: one beat per op. op = start resets the derivation to <e><o><e>;
//  op = codon expands the leftmost nonterminal. req_ready is high only while
//  the block is idle; one beat is in work at a time.
//  rsp channel: every request gives 1 to 32 beats: leading closing brackets,
//  the token of the expansion, trailing closing brackets. Every beat carries
//  the status and working length after the whole request; last marks the end.
//  csr channel: always ready; writes max_length. Write only while idle.
//  Steps: start lays down <e><o><e>, then its beat. A codon does each stack
//  look-up as a registered stack read, then a decision; an even codon then
//  pushes its bracket expansion, then a finish step, then one beat per cycle
//  with rsp_ready high. The stack memory's write port and read register set
//  these steps. Next request is taken the cycle after the last beat.
//  Reset: status idle, length 0, stack empty, max_length 200. The stack
//  memory is not cleared; only entries below the stack count are read.
//  A stalled receiver holds the beat stable and the block waits.
module grammar_codon_expression_mapper_core
   import gcem_pkg::*;
#(
   parameter int STACK_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(STACK_DEPTH);

   map_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [7:0]          len_ff, len_in;
   logic [1:0]          status_ff, status_in;
   logic [7:0]          max_ff;
   logic [5:0]          pre_ff, pre_in;
   logic [5:0]          post_ff, post_in;
   logic                mid_ff, mid_in;
   logic [3:0]          mid_tok_ff, mid_tok_in;
   logic                phase_ff, phase_in;    // 1 once the codon is applied
   logic [1:0]          idx_ff, idx_in;
   logic [7:0]          codon_ff, codon_in;

   sym_type             stack_mem [STACK_DEPTH];
   sym_type             rd_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   sym_type             mem_wdata;
   logic [ADDR_W-1:0]   top_addr;

   logic                count_nz;
   logic                too_long;
   logic [6:0]          beats_so_far;
   logic [6:0]          beats_left;
   logic [1:0]          codon_m3;

   assign csr_ready    = 1'b1;
   assign top_addr     = ADDR_W'(count_ff - CNT_W'(1));
   assign count_nz     = (count_ff != '0);
   assign codon_m3     = mod3_u8(codon_ff);
   assign too_long     = ({1'b0, len_ff} + 9'd8 > {1'b0, max_ff}) ||
                         ({1'b0, count_ff} + (CNT_W + 1)'(3) > DEPTH_C);
   assign beats_so_far = 7'(pre_ff) + 7'(post_ff) + 7'(mid_ff);
   assign beats_left   = beats_so_far;

   always_comb begin
      rsp_payload.token         = (pre_ff != '0) ? TOK_CLOSE :
                                  (mid_ff ? mid_tok_ff : TOK_CLOSE);
      rsp_payload.status        = status_ff;
      rsp_payload.string_length = len_ff;
      rsp_payload.last          = (beats_left == 7'd1);
   end

   // Stack memory: one write port, registered read of the top entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= stack_mem[top_addr];
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      status_in  = status_ff;
      pre_in     = pre_ff;
      post_in    = post_ff;
      mid_in     = mid_ff;
      mid_tok_in = mid_tok_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      codon_in   = codon_ff;
      mem_we     = 1'b0;
      mem_waddr  = top_addr;
      mem_wdata  = SYM_E;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               codon_in   = req_payload.codon;
               pre_in     = '0;
               post_in    = '0;
               mid_in     = 1'b0;
               mid_tok_in = TOK_NONE;
               phase_in   = 1'b0;
               idx_in     = '0;
               if (req_payload.op == OP_START) begin
                  count_in  = '0;
                  len_in    = LEN_START;
                  status_in = STAT_RUN;
                  mid_in    = 1'b1;
                  state_in  = ST_INIT;
               end else if (status_ff != STAT_RUN) begin
                  mid_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_INIT: begin
            // lay down <e><o><e> bottom up
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(idx_ff);
            mem_wdata = (idx_ff == 2'd1) ? SYM_O : SYM_E;
            idx_in    = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               count_in = CNT_W'(3);
               state_in = ST_EMIT;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!phase_ff) begin
               if (count_nz && rd_ff == SYM_CLOSE) begin
                  // leading close; at the cap the codon is dropped
                  count_in = count_ff - CNT_W'(1);
                  pre_in   = pre_ff + 6'd1;
                  state_in = (pre_ff == PRE_MAX) ? ST_FINISH : ST_READ;
               end else if (count_nz) begin
                  mid_in = 1'b1;
                  unique case (rd_ff)
                     SYM_E: begin
                        if (codon_ff[0]) begin
                           mem_we     = 1'b1;
                           mem_wdata  = SYM_V;
                           mid_tok_in = TOK_NONE;
                           phase_in   = 1'b1;
                           state_in   = ST_READ;
                        end else if (too_long) begin
                           status_in  = STAT_LONG;
                           mid_tok_in = TOK_NONE;
                           state_in   = ST_FINISH;
                        end else begin
                           len_in     = len_ff + 8'd8;
                           mid_tok_in = TOK_OPEN;
                           idx_in     = '0;
                           state_in   = ST_PUSH;
                        end
                     end
                     SYM_O, SYM_V: begin
                        count_in   = count_ff - CNT_W'(1);
                        len_in     = len_ff - 8'd2;
                        mid_tok_in = ((rd_ff == SYM_V) ? TOK_VAR : TOK_ARITH) +
                                     4'(codon_m3);
                        phase_in   = 1'b1;
                        state_in   = ST_READ;
                     end
                     SYM_CLOSE: begin
                        state_in = ST_FINISH;
                     end
                  endcase
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               if (count_nz && rd_ff == SYM_CLOSE && beats_so_far < MAX_BEATS) begin
                  count_in = count_ff - CNT_W'(1);
                  post_in  = post_ff + 6'd1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PUSH: begin
            // top e becomes close, then e o e pushed above it
            mem_we    = 1'b1;
            mem_waddr = top_addr + ADDR_W'(idx_ff);
            unique case (idx_ff)
               2'd0: mem_wdata = SYM_CLOSE;
               2'd1: mem_wdata = SYM_E;
               2'd2: mem_wdata = SYM_O;
               2'd3: mem_wdata = SYM_E;
            endcase
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               count_in = count_ff + CNT_W'(3);
               phase_in = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (status_ff == STAT_RUN && !count_nz) begin
               status_in = STAT_DONE;
            end
            if (beats_so_far == '0) begin
               mid_in     = 1'b1;
               mid_tok_in = TOK_NONE;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (pre_ff != '0) begin
                  pre_in = pre_ff - 6'd1;
               end else if (mid_ff) begin
                  mid_in = 1'b0;
               end else begin
                  post_in = post_ff - 6'd1;
               end
               if (beats_left == 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         len_ff    <= '0;
         status_ff <= STAT_IDLE;
         max_ff    <= MAX_LEN_RST;
         pre_ff    <= '0;
         post_ff   <= '0;
         mid_ff    <= 1'b0;
         phase_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         status_ff <= status_in;
         pre_ff    <= pre_in;
         post_ff   <= post_in;
         mid_ff    <= mid_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      mid_tok_ff <= mid_tok_in;
      codon_ff   <= codon_in;
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response beats pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= DEPTH_C)
      else $error("stack count beyond depth");

   a_beat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (beats_left != '0 && beats_left <= MAX_BEATS))
      else $error("response beat count out of range");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last) |=> req_ready)
      else $error("block not ready after final beat");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (req_ready && status_ff == STAT_DONE) |-> !count_nz)
      else $error("derivation complete with symbols pending");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for grammar_codon_expression_mapper_core: random and directed
// codon beats, with every response beat checked against an in-bench derivation model.
// Depends on gcem_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
   import gcem_pkg::*;

   localparam int DEPTH       = 128;
   localparam int MAX_TOKENS  = 32;
   localparam int QUIET_LIMIT = 4000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_wdata   = 8'd0;

   grammar_codon_expression_mapper_core #(.STACK_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Two copies of the derivation state: 0 tracks accepted beats for checking,
   // 1 runs ahead while the stimulus is planned.
   sym_type     sym_stack [2][DEPTH];
   int unsigned sym_count [2];
   int unsigned work_len  [2];
   logic [1:0]  deriv_stat[2];
   int unsigned len_limit [2];

   logic [3:0] token_q[$];
   rsp_type    expected_beats[$];
   req_type    pending_reqs[$];

   int   errors       = 0;
   int   send_idle    = 0;
   int   recv_stall   = 0;
   int   quiet_cycles = 0;
   logic req_taken    = 1'b0;

   function automatic void pop_brackets(input int w, input int lim);
      while (token_q.size() < lim && sym_count[w] > 0 &&
             sym_stack[w][sym_count[w] - 1] == SYM_CLOSE) begin
         sym_count[w]--;
         token_q.push_back(TOK_CLOSE);
      end
   endfunction

   // Applies one request beat to copy w; the tokens it emits land in token_q
   function automatic void derive_step(input int w, input req_type r);
      sym_type top;
      token_q.delete();
      if (r.op == OP_START) begin
         sym_stack[w][0] = SYM_E;
         sym_stack[w][1] = SYM_O;
         sym_stack[w][2] = SYM_E;
         sym_count[w]    = 3;
         work_len[w]     = 9;
         deriv_stat[w]   = STAT_RUN;
         token_q.push_back(TOK_NONE);
      end else if (deriv_stat[w] != STAT_RUN) begin
         token_q.push_back(TOK_NONE);
      end else begin
         pop_brackets(w, MAX_TOKENS - 1);
         if (sym_count[w] > 0 && sym_stack[w][sym_count[w] - 1] != SYM_CLOSE) begin
            top = sym_stack[w][sym_count[w] - 1];
            if (top == SYM_E) begin
               if (r.codon[0]) begin
                  sym_stack[w][sym_count[w] - 1] = SYM_V;
                  token_q.push_back(TOK_NONE);
               end else if (work_len[w] + 8 > len_limit[w] || sym_count[w] + 3 > DEPTH) begin
                  deriv_stat[w] = STAT_LONG;
                  token_q.push_back(TOK_NONE);
               end else begin
                  sym_stack[w][sym_count[w] - 1] = SYM_CLOSE;
                  sym_stack[w][sym_count[w]]     = SYM_E;
                  sym_stack[w][sym_count[w] + 1] = SYM_O;
                  sym_stack[w][sym_count[w] + 2] = SYM_E;
                  sym_count[w] += 3;
                  work_len[w]  += 8;
                  token_q.push_back(TOK_OPEN);
               end
            end else begin
               sym_count[w]--;
               work_len[w] -= 2;
               token_q.push_back((top == SYM_V ? TOK_VAR : TOK_ARITH) + 4'(r.codon % 3));
            end
            if (deriv_stat[w] == STAT_RUN) begin
               pop_brackets(w, MAX_TOKENS);
            end
         end else if (sym_count[w] > 0 && token_q.size() < MAX_TOKENS) begin
            // bracket run too long: codon dropped, one more bracket goes out
            pop_brackets(w, token_q.size() + 1);
         end
         if (deriv_stat[w] == STAT_RUN && sym_count[w] == 0) begin
            deriv_stat[w] = STAT_DONE;
         end
         if (token_q.size() == 0) begin
            token_q.push_back(TOK_NONE);
         end
      end
   endfunction

   task automatic queue_req(input logic op, input logic [7:0] codon);
      req_type r;
      r.op    = op;
      r.codon = codon;
      derive_step(1, r);
      pending_reqs.push_back(r);
   endtask

   // Mostly well-formed derivations; some stray codons and early restarts
   task automatic plan_random(input int n);
      int      made;
      req_type r;
      made = 0;
      while (made < n) begin
         r.op    = OP_CODON;
         r.codon = 8'($urandom_range(0, 255));
         if (deriv_stat[1] != STAT_RUN) begin
            if ($urandom_range(99) >= 15) begin
               r.op = OP_START;
            end
         end else if ($urandom_range(99) < 3) begin
            r.op = OP_START;
         end else if ($urandom_range(99) < 20) begin
            r.codon[0] = 1'b1;   // steer towards completion
         end
         if (r.op == OP_START || deriv_stat[1] == STAT_RUN) begin
            made++;
         end
         derive_step(1, r);
         pending_reqs.push_back(r);
      end
   endtask

   task automatic write_limit(input logic [7:0] v);
      @(negedge clock);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      len_limit[0] = v;
      len_limit[1] = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_quiet;
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_beats.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Request driver and receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_payload <= pending_reqs.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // Response checker, prediction on request acceptance, watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_beats.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat: expected none,", $realtime,
                        " got token %0d status %0d length %0d last %0b",
                        rsp_payload.token, rsp_payload.status,
                        rsp_payload.string_length, rsp_payload.last);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_payload.token !== want.token || rsp_payload.status !== want.status ||
                   rsp_payload.string_length !== want.string_length ||
                   rsp_payload.last !== want.last) begin
                  errors++;
                  $display("%0t: beat mismatch: expected token %0d status %0d",
                           $realtime, want.token, want.status,
                           " length %0d last %0b,", want.string_length, want.last,
                           " got token %0d status %0d length %0d last %0b",
                           rsp_payload.token, rsp_payload.status,
                           rsp_payload.string_length, rsp_payload.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            req_taken = 1'b1;
            derive_step(0, req_payload);
            foreach (token_q[i]) begin
               want.token         = token_q[i];
               want.status        = deriv_stat[0];
               want.string_length = work_len[0][7:0];
               want.last          = (i == token_q.size() - 1);
               expected_beats.push_back(want);
            end
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      for (int w = 0; w < 2; w++) begin
         sym_count[w]  = 0;
         work_len[w]   = 0;
         deriv_stat[w] = STAT_IDLE;
         len_limit[w]  = 200;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-length limit, no idling: every production, stray codons, completion
      write_limit(8'd200);
      queue_req(OP_CODON, 8'hFF);   // before any start
      queue_req(OP_START, 8'hFF);
      queue_req(OP_CODON, 8'd0);    // bracketed expansion
      queue_req(OP_CODON, 8'd1);    // e to v
      queue_req(OP_CODON, 8'd0);    // x
      queue_req(OP_CODON, 8'd1);    // minus
      queue_req(OP_CODON, 8'd3);
      queue_req(OP_CODON, 8'd2);    // one, bracket follows
      queue_req(OP_CODON, 8'd3);    // plus
      queue_req(OP_CODON, 8'd255);
      queue_req(OP_CODON, 8'd4);    // y, derivation complete
      queue_req(OP_CODON, 8'h80);   // after completion
      queue_req(OP_START, 8'd0);
      queue_req(OP_CODON, 8'd5);
      queue_req(OP_CODON, 8'd128);
      queue_req(OP_CODON, 8'd2);    // times
      queue_req(OP_CODON, 8'd254);
      plan_random(30);
      wait_quiet();

      // Tightest limit, idle sender: any bracket overflows at once
      write_limit(8'd9);
      send_idle = 69;
      queue_req(OP_START, 8'd0);
      queue_req(OP_CODON, 8'd0);
      queue_req(OP_CODON, 8'd1);    // after overflow
      queue_req(OP_START, 8'd0);
      plan_random(15);
      wait_quiet();

      write_limit(8'($urandom_range(17, 120)));
      send_idle  = 0;
      recv_stall = 69;
      plan_random(40);
      wait_quiet();

      write_limit(8'd200);
      send_idle  = 8;
      recv_stall = 8;
      plan_random(40);
      wait_quiet();

      write_limit(8'd40);
      send_idle  = 0;
      recv_stall = 0;
      plan_random(25);
      wait_quiet();

      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
rtl/gcem_pkg.sv
rtl/grammar_codon_expression_mapper_core.sv
bench/tb_top.sv
